// File: hdl/cbwa_pkg.sv
// shared types, codes and helpers for the cell binned weighted average block
// no dependencies
package cbwa_pkg;

    localparam int NUM_CELLS_DEF = 1024;

    // input kinds
    localparam logic [2:0] K_ADD     = 3'd0;
    localparam logic [2:0] K_REMOVE  = 3'd1;
    localparam logic [2:0] K_CORRECT = 3'd2;
    localparam logic [2:0] K_QUERY   = 3'd3;
    localparam logic [2:0] K_LOAD    = 3'd4;

    // back end operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_QUERY  = 3'd3;
    localparam logic [2:0] OP_LOAD   = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ORDER     = 3'd1;
    localparam logic [2:0] ST_NEG_COUNT = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_ZERO_DIV  = 3'd4;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic        clr;       // clear the difference bank first
        logic        to_diff;
        logic [2:0]  status;
        logic [31:0] dw;
        logic [47:0] dv;
        logic [31:0] raw;       // denominator for a load
    } t_cmd;

    typedef struct packed {
        logic [31:0] count;
        logic [47:0] wsum;
        logic [47:0] vsum;
    } t_bank;

    typedef struct packed {
        logic  touched;
        t_bank bank;
    } t_dbank;

    // clamp a 49-bit sum of two 48-bit values to 48 bits
    function automatic logic [47:0] sat48(input logic [48:0] x);
        logic [47:0] r;
        if (x[48] != x[47]) begin
            r = x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            r = x[47:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/cbwa_front.sv
// front end: accepts beats, tracks batch order and forms back end commands
// depends on cbwa_pkg
module cbwa_front #(
    parameter int NUM_CELLS = cbwa_pkg::NUM_CELLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_kind,
    input  logic                  i_first_of_batch,
    input  logic                  i_to_cache,
    input  logic [9:0]            i_cell_req,
    input  logic signed [31:0]    i_value,
    input  logic [31:0]           i_weight,
    input  logic                  i_internal_weights,
    input  logic                  i_init_busy,
    input  logic                  i_full,
    output logic                  o_push,
    output cbwa_pkg::t_cmd        o_cmd,
    output logic [(NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1)-1:0] o_cell
);

    localparam int CW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    logic          r_valid;
    logic          r_cached, n_cached;
    logic          r_batch_ok, n_batch_ok;
    logic          r_batch_to_diff, n_batch_to_diff;
    logic [2:0]    r_op, n_op;
    logic          r_clr, n_clr;
    logic [2:0]    r_status, n_status;
    logic [CW-1:0] r_cell;
    logic [31:0]   r_value;
    logic [31:0]   r_weight;
    logic          r_iw;
    logic          r_neg;
    logic          r_to_diff;
    logic [63:0]   r_prod;

    logic          accept;
    logic          in_range;
    logic [31:0]   v_mag;
    logic [63:0]   prod;
    logic [63:0]   prod_rnd;

    assign o_stall  = i_init_busy || (r_valid && i_full);
    assign accept   = i_valid && !o_stall;
    assign o_push   = r_valid && !i_full;
    assign in_range = (32'(i_cell_req) < NUM_CELLS);
    assign v_mag    = i_value[31] ? (~i_value + 32'd1) : i_value;
    assign prod     = v_mag * i_weight;

    always_comb begin
        n_cached        = r_cached;
        n_batch_ok      = r_batch_ok;
        n_batch_to_diff = r_batch_to_diff;
        n_op            = cbwa_pkg::OP_NONE;
        n_clr           = 1'b0;
        n_status        = cbwa_pkg::ST_OK;
        if (i_kind == cbwa_pkg::K_ADD || i_kind == cbwa_pkg::K_REMOVE ||
            i_kind == cbwa_pkg::K_CORRECT) begin
            if (i_first_of_batch) begin
                unique case (i_kind)
                    cbwa_pkg::K_ADD: begin
                        n_batch_ok = !r_cached;
                        if (!r_cached) n_cached = i_to_cache;
                        n_batch_to_diff = i_to_cache;
                    end
                    cbwa_pkg::K_CORRECT: begin
                        n_batch_ok = r_cached;
                        if (r_cached) begin
                            n_cached = i_to_cache;
                            n_clr    = 1'b1;
                        end
                        n_batch_to_diff = i_to_cache;
                    end
                    default: begin
                        n_batch_ok      = !r_cached;
                        n_batch_to_diff = 1'b0;
                    end
                endcase
            end
            if (!n_batch_ok) begin
                n_status = cbwa_pkg::ST_ORDER;
            end else if (in_range) begin
                n_op = (i_kind == cbwa_pkg::K_REMOVE) ? cbwa_pkg::OP_REMOVE : cbwa_pkg::OP_ADD;
            end
        end else if (i_kind == cbwa_pkg::K_QUERY) begin
            if (in_range) n_op = cbwa_pkg::OP_QUERY;
            else n_status = cbwa_pkg::ST_EMPTY;
        end else if (i_kind == cbwa_pkg::K_LOAD && in_range) begin
            n_op = cbwa_pkg::OP_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= 1'b0;
            r_cached        <= 1'b0;
            r_batch_ok      <= 1'b0;
            r_batch_to_diff <= 1'b0;
        end else if (accept) begin
            r_valid         <= 1'b1;
            r_cached        <= n_cached;
            r_batch_ok      <= n_batch_ok;
            r_batch_to_diff <= n_batch_to_diff;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= n_op;
            r_clr     <= n_clr;
            r_status  <= n_status;
            r_to_diff <= n_batch_to_diff;
            r_cell    <= CW'(32'(i_cell_req));
            r_value   <= i_value;
            r_weight  <= i_weight;
            r_iw      <= i_internal_weights;
            r_neg     <= i_value[31];
            r_prod    <= prod;
        end
    end

    // floor of weight * value in q16.16, rounding toward minus infinity
    assign prod_rnd = r_prod + 64'h0000_0000_0000_FFFF;

    always_comb begin
        o_cmd.op      = r_op;
        o_cmd.clr     = r_clr;
        o_cmd.to_diff = r_to_diff;
        o_cmd.status  = r_status;
        o_cmd.raw     = r_value;
        if (r_iw) begin
            o_cmd.dw = r_weight;
            o_cmd.dv = r_neg ? (48'd0 - prod_rnd[63:16]) : r_prod[63:16];
        end else begin
            o_cmd.dw = 32'd0;
            o_cmd.dv = {{16{r_value[31]}}, r_value};
        end
    end

    assign o_cell = r_cell;

endmodule

// File: hdl/cbwa_queue.sv
// two-entry command queue between front and back end
// no dependencies
module cbwa_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            if (i_push && !i_pop) r_cnt <= r_cnt + 2'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// File: hdl/cbwa_div.sv
// radix-2 restoring divider: 32-bit q16.16 quotient magnitude of two 49-bit values
// no dependencies
module cbwa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [48:0] i_num,
    input  logic [48:0] i_den,
    output logic        o_done,
    output logic [31:0] o_mag,
    output logic        o_ovf,
    output logic        o_neg
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_ABS  = 2'd1;
    localparam logic [1:0] D_CHK  = 2'd2;
    localparam logic [1:0] D_RUN  = 2'd3;

    logic [1:0]  r_state;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [48:0] r_num;
    logic [48:0] r_den;
    logic [48:0] r_an;
    logic [48:0] r_ad;
    logic [48:0] r_rem;
    logic [15:0] r_bits;
    logic [31:0] r_q;
    logic        r_ovf;
    logic        r_neg;

    logic [49:0] shifted;
    logic        q_bit;

    assign shifted = {r_rem, r_bits[15]};
    assign q_bit   = (shifted >= {1'b0, r_ad});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: if (i_start) r_state <= D_ABS;
                D_ABS:  r_state <= D_CHK;
                D_CHK: begin
                    if (r_an[48:16] >= {16'd0, r_ad[48:32]} && r_an[48:16] >= r_ad[32:0] &&
                        r_ad[48:33] == 16'd0) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (r_cnt == 5'd31) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_num <= i_num;
                    r_den <= i_den;
                end
            end
            D_ABS: begin
                r_neg <= r_num[48] ^ r_den[48];
                r_an  <= r_num[48] ? (~r_num + 49'd1) : r_num;
                r_ad  <= r_den[48] ? (~r_den + 49'd1) : r_den;
            end
            D_CHK: begin
                // integer part of the quotient reaching 2^16 saturates
                r_ovf  <= (r_ad[48:33] == 16'd0) && (r_an[48:16] >= r_ad[32:0]);
                r_rem  <= {16'd0, r_an[48:16]};
                r_bits <= r_an[15:0];
                r_q    <= 32'd0;
                r_cnt  <= 5'd0;
            end
            default: begin
                r_rem  <= q_bit ? 49'(shifted - {1'b0, r_ad}) : shifted[48:0];
                r_bits <= {r_bits[14:0], 1'b0};
                r_q    <= {r_q[30:0], q_bit};
                r_cnt  <= r_cnt + 5'd1;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_mag  = r_q;
    assign o_ovf  = r_ovf;
    assign o_neg  = r_neg;

endmodule

// File: hdl/cbwa_back.sv
// back end: per-cell bank memories, touched list, clearing sweeps, query divide
// depends on cbwa_pkg and cbwa_div
module cbwa_back #(
    parameter int NUM_CELLS = cbwa_pkg::NUM_CELLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  cbwa_pkg::t_cmd        i_q_cmd,
    input  logic [(NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1)-1:0] i_q_cell,
    output logic                  o_pop,
    input  logic                  i_internal_weights,
    output logic                  o_init_busy,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_status,
    output logic                  o_mean_valid,
    output logic signed [31:0]    o_mean
);

    localparam int CW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CNTW = $clog2(NUM_CELLS + 1);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DFIN = 3'd5;

    cbwa_pkg::t_bank  m_main [NUM_CELLS];
    cbwa_pkg::t_dbank m_diff [NUM_CELLS];
    logic [CW-1:0]    m_list [NUM_CELLS];
    logic [31:0]      m_den  [NUM_CELLS];

    logic [2:0]       r_state, n_state;
    cbwa_pkg::t_cmd   r_cmd, n_cmd;
    logic [CW-1:0]    r_cell, n_cell;
    logic [CW-1:0]    r_init_idx, n_init_idx;
    logic [CNTW-1:0]  r_touch_cnt, n_touch_cnt;
    logic [CNTW-1:0]  r_clr_idx, n_clr_idx;
    logic             r_clr_pend, n_clr_pend;
    logic             r_o_valid, n_o_valid;
    logic [2:0]       r_o_status, n_o_status;
    logic             r_o_mean_valid, n_o_mean_valid;
    logic [31:0]      r_o_mean, n_o_mean;

    cbwa_pkg::t_bank  r_main_q;
    cbwa_pkg::t_dbank r_diff_q;
    logic [31:0]      r_den_q;
    logic [CW-1:0]    r_list_q;

    logic             bank_re;
    logic [CW-1:0]    rd_addr;
    logic             main_we;
    logic [CW-1:0]    main_waddr;
    cbwa_pkg::t_bank  main_wdata;
    logic             diff_we;
    logic [CW-1:0]    diff_waddr;
    cbwa_pkg::t_dbank diff_wdata;
    logic             list_we;
    logic             list_re;
    logic             den_we;

    logic             out_free;
    logic             emit;
    logic [2:0]       emit_status;
    logic             emit_mv;
    logic [31:0]      emit_mean;
    logic             have_m;
    logic             have_d;
    logic [48:0]      q_num;
    logic [48:0]      q_den;

    logic             div_start;
    logic             div_done;
    logic [31:0]      div_mag;
    logic             div_ovf;
    logic             div_neg;

    // the divider latches the operands in the cycle it is started
    cbwa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (q_num),
        .i_den   (q_den),
        .o_done  (div_done),
        .o_mag   (div_mag),
        .o_ovf   (div_ovf),
        .o_neg   (div_neg)
    );

    assign out_free    = !r_o_valid || !i_stall;
    assign o_init_busy = (r_state == S_INIT);
    assign have_m      = (r_main_q.count != 32'd0);
    assign have_d      = (r_diff_q.bank.count != 32'd0);

    always_comb begin
        q_num = (have_m ? {r_main_q.vsum[47], r_main_q.vsum} : 49'd0) +
                (have_d ? {r_diff_q.bank.vsum[47], r_diff_q.bank.vsum} : 49'd0);
        if (i_internal_weights) begin
            q_den = (have_m ? {r_main_q.wsum[47], r_main_q.wsum} : 49'd0) +
                    (have_d ? {r_diff_q.bank.wsum[47], r_diff_q.bank.wsum} : 49'd0);
        end else begin
            q_den = {{17{r_den_q[31]}}, r_den_q};
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_cell         = r_cell;
        n_init_idx     = r_init_idx;
        n_touch_cnt    = r_touch_cnt;
        n_clr_idx      = r_clr_idx;
        n_clr_pend     = 1'b0;
        n_o_valid      = r_o_valid && i_stall;
        n_o_status     = r_o_status;
        n_o_mean_valid = r_o_mean_valid;
        n_o_mean       = r_o_mean;
        o_pop          = 1'b0;
        bank_re        = 1'b0;
        rd_addr        = r_cell;
        main_we        = 1'b0;
        main_waddr     = r_cell;
        main_wdata     = '0;
        diff_we        = 1'b0;
        diff_waddr     = r_cell;
        diff_wdata     = '0;
        list_we        = 1'b0;
        list_re        = 1'b0;
        den_we         = 1'b0;
        div_start      = 1'b0;
        emit           = 1'b0;
        emit_status    = r_cmd.status;
        emit_mv        = 1'b0;
        emit_mean      = 32'd0;

        unique case (r_state)
            S_INIT: begin
                main_we    = 1'b1;
                diff_we    = 1'b1;
                main_waddr = r_init_idx;
                diff_waddr = r_init_idx;
                if (r_init_idx == CW'(NUM_CELLS - 1)) n_state = S_IDLE;
                else n_init_idx = r_init_idx + 1'b1;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_q_cmd;
                    n_cell = i_q_cell;
                    if (i_q_cmd.clr) begin
                        n_clr_idx = '0;
                        n_state   = S_CLR;
                    end else begin
                        bank_re = 1'b1;
                        rd_addr = i_q_cell;
                        n_state = S_EXEC;
                    end
                end
            end
            S_CLR: begin
                // list read one cycle, clear of that cell the next
                if (r_clr_pend) begin
                    diff_we    = 1'b1;
                    diff_waddr = r_list_q;
                end
                if (r_clr_idx != r_touch_cnt) begin
                    list_re    = 1'b1;
                    n_clr_idx  = r_clr_idx + 1'b1;
                    n_clr_pend = 1'b1;
                end else if (!r_clr_pend) begin
                    n_touch_cnt = '0;
                    bank_re     = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    case (r_cmd.op)
                        cbwa_pkg::OP_ADD: begin
                            if (r_cmd.to_diff) begin
                                diff_we = 1'b1;
                                diff_wdata.touched = r_diff_q.touched;
                                diff_wdata.bank.count =
                                    (r_diff_q.bank.count == cbwa_pkg::COUNT_MAX) ?
                                    r_diff_q.bank.count : r_diff_q.bank.count + 32'd1;
                                diff_wdata.bank.wsum = cbwa_pkg::sat48(
                                    {r_diff_q.bank.wsum[47], r_diff_q.bank.wsum} +
                                    {17'd0, r_cmd.dw});
                                diff_wdata.bank.vsum = cbwa_pkg::sat48(
                                    {r_diff_q.bank.vsum[47], r_diff_q.bank.vsum} +
                                    {r_cmd.dv[47], r_cmd.dv});
                                if (!r_diff_q.touched && r_touch_cnt != CNTW'(NUM_CELLS)) begin
                                    diff_wdata.touched = 1'b1;
                                    list_we     = 1'b1;
                                    n_touch_cnt = r_touch_cnt + 1'b1;
                                end
                            end else begin
                                main_we = 1'b1;
                                main_wdata.count = (r_main_q.count == cbwa_pkg::COUNT_MAX) ?
                                    r_main_q.count : r_main_q.count + 32'd1;
                                main_wdata.wsum = cbwa_pkg::sat48(
                                    {r_main_q.wsum[47], r_main_q.wsum} + {17'd0, r_cmd.dw});
                                main_wdata.vsum = cbwa_pkg::sat48(
                                    {r_main_q.vsum[47], r_main_q.vsum} +
                                    {r_cmd.dv[47], r_cmd.dv});
                            end
                        end
                        cbwa_pkg::OP_REMOVE: begin
                            if (!have_m) begin
                                emit_status = cbwa_pkg::ST_NEG_COUNT;
                            end else begin
                                main_we = 1'b1;
                                main_wdata.count = r_main_q.count - 32'd1;
                                main_wdata.wsum = cbwa_pkg::sat48(
                                    {r_main_q.wsum[47], r_main_q.wsum} - {17'd0, r_cmd.dw});
                                main_wdata.vsum = cbwa_pkg::sat48(
                                    {r_main_q.vsum[47], r_main_q.vsum} -
                                    {r_cmd.dv[47], r_cmd.dv});
                            end
                        end
                        cbwa_pkg::OP_LOAD: begin
                            den_we = 1'b1;
                        end
                        cbwa_pkg::OP_QUERY: begin
                            if (!have_m && !have_d) begin
                                emit_status = cbwa_pkg::ST_EMPTY;
                            end else if (q_den == 49'd0) begin
                                emit_status = cbwa_pkg::ST_ZERO_DIV;
                            end else begin
                                emit      = 1'b0;
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) n_state = S_DFIN;
            end
            S_DFIN: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = cbwa_pkg::ST_OK;
                    emit_mv     = 1'b1;
                    n_state     = S_IDLE;
                    if (div_neg) begin
                        if (div_ovf || div_mag > 32'h8000_0000) emit_mean = 32'h8000_0000;
                        else emit_mean = 32'd0 - div_mag;
                    end else begin
                        if (div_ovf || div_mag[31]) emit_mean = 32'h7FFF_FFFF;
                        else emit_mean = div_mag;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (emit) begin
            n_o_valid      = 1'b1;
            n_o_status     = emit_status;
            n_o_mean_valid = emit_mv;
            n_o_mean       = emit_mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_idx  <= '0;
            r_touch_cnt <= '0;
            r_clr_pend  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_idx  <= n_init_idx;
            r_touch_cnt <= n_touch_cnt;
            r_clr_pend  <= n_clr_pend;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd          <= n_cmd;
        r_cell         <= n_cell;
        r_clr_idx      <= n_clr_idx;
        r_o_status     <= n_o_status;
        r_o_mean_valid <= n_o_mean_valid;
        r_o_mean       <= n_o_mean;
    end

    always_ff @(posedge i_clk) begin
        if (main_we) m_main[main_waddr] <= main_wdata;
        if (bank_re) r_main_q <= m_main[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (diff_we) m_diff[diff_waddr] <= diff_wdata;
        if (bank_re) r_diff_q <= m_diff[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (list_we) m_list[r_touch_cnt[CW-1:0]] <= r_cell;
        if (list_re) r_list_q <= m_list[r_clr_idx[CW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (den_we) m_den[r_cell] <= r_cmd.raw;
        if (bank_re) r_den_q <= m_den[rd_addr];
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_mean_valid = r_o_mean_valid;
    assign o_mean       = r_o_mean;

endmodule

// File: hdl/cell_binned_weighted_average.sv
// top level: per-cell weighted average with main and cached-difference banks
// add, remove, load and status-only beats pass the front register, the queue, the bank
//   read and the result register; the back end reads then writes the bank memory per beat
// query: runs the 32-step radix-2 divider; a correct batch start first does the clearing
//   walk over the touched list, clearing each touched cell of the difference bank
// reset: synchronous; afterwards a sweep over all NUM_CELLS cells zeroes both banks,
//   input stalled meanwhile; the configuration register resets to internal weighting
module cell_binned_weighted_average #(
    parameter int NUM_CELLS = cbwa_pkg::NUM_CELLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_kind,
    input  logic                i_first_of_batch,
    input  logic                i_to_cache,
    input  logic [9:0]          i_cell_req,
    input  logic signed [31:0]  i_value,
    input  logic [31:0]         i_weight,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic                o_mean_valid,
    output logic signed [31:0]  o_mean
);

    localparam int CW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int QW = $bits(cbwa_pkg::t_cmd) + CW;

    // weighting mode; the user must change it only while idle, the block does not enforce this
    logic r_internal_weights;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_internal_weights <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_internal_weights <= i_cfg_wr_data;
        end
    end

    // front to queue
    logic           push;
    cbwa_pkg::t_cmd f_cmd;
    logic [CW-1:0]  f_cell;
    logic           q_full;
    // queue to back
    logic           pop;
    logic           q_valid;
    logic [QW-1:0]  q_data;
    cbwa_pkg::t_cmd b_cmd;
    logic [CW-1:0]  b_cell;
    logic           init_busy;

    // batch order checks and weighted value product happen in the front
    cbwa_front #(
        .NUM_CELLS (NUM_CELLS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_kind             (i_kind),
        .i_first_of_batch   (i_first_of_batch),
        .i_to_cache         (i_to_cache),
        .i_cell_req         (i_cell_req),
        .i_value            (i_value),
        .i_weight           (i_weight),
        .i_internal_weights (r_internal_weights),
        .i_init_busy        (init_busy),
        .i_full             (q_full),
        .o_push             (push),
        .o_cmd              (f_cmd),
        .o_cell             (f_cell)
    );

    // short queue so the front keeps taking beats while the back divides or sweeps
    cbwa_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_cell}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign b_cmd  = q_data[QW-1:CW];
    assign b_cell = q_data[CW-1:0];

    // bank memories, touched list walk, queries and the result register
    cbwa_back #(
        .NUM_CELLS (NUM_CELLS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_cmd            (b_cmd),
        .i_q_cell           (b_cell),
        .o_pop              (pop),
        .i_internal_weights (r_internal_weights),
        .o_init_busy        (init_busy),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_mean_valid       (o_mean_valid),
        .o_mean             (o_mean)
    );

endmodule
